FILE: rtl/rss_pkg.sv
// Shared types and constants for the RGB 3x3 sharpen stream.
// Used by every module of the block but rss_ram; depends on nothing.
package rss_pkg;

   localparam int MAX_WIDTH = 2048;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int WIDTH_W   = 12;
   localparam int HEIGHT_W  = 16;
   localparam int CSR_DATA_W = 16;

   localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 12'd640;
   localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 16'd480;
   localparam logic [WIDTH_W-1:0]  MIN_WIDTH    = 12'd2;
   localparam logic [WIDTH_W-1:0]  LIMIT_WIDTH  = WIDTH_W'(MAX_WIDTH);
   localparam logic [HEIGHT_W-1:0] MIN_HEIGHT   = 16'd2;

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   typedef logic [23:0] pixel_type;
   typedef pixel_type [2:0] column_type;

   typedef struct packed {
      logic             emit;
      logic             first;
      logic             second;
      logic             top;
      logic             bot;
      logic             fend;
      logic [COL_W-1:0] col;
      pixel_type        pix;
   } stage_type;

endpackage

FILE: rtl/rss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module rss_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/rss_cell.sv
// One column cell of the 3x3 window: holds three pixels and passes them on.
// Depends on rss_pkg.
module rss_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  rss_pkg::column_type col_in,
   output rss_pkg::column_type col_out
);

   rss_pkg::column_type col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (shift) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

endmodule

FILE: rtl/rss_filter.sv
// Sharpen kernel for one pixel: 5*center minus four neighbors, clipped 0..255.
// Depends on rss_pkg.
module rss_filter (
   input  rss_pkg::pixel_type center,
   input  rss_pkg::pixel_type up,
   input  rss_pkg::pixel_type down,
   input  rss_pkg::pixel_type left,
   input  rss_pkg::pixel_type right,
   output rss_pkg::pixel_type result
);

   always_comb begin
      logic signed [11:0] sum;
      result = '0;
      for (int k = 0; k < 3; k++) begin
         sum = $signed({2'b00, center[8*k +: 8], 2'b00}) + $signed({4'b0, center[8*k +: 8]})
             - $signed({4'b0, up[8*k +: 8]}) - $signed({4'b0, down[8*k +: 8]})
             - $signed({4'b0, left[8*k +: 8]}) - $signed({4'b0, right[8*k +: 8]});
         if (sum < 0) begin
            result[8*k +: 8] = 8'd0;
         end else if (sum > 12'sd255) begin
            result[8*k +: 8] = 8'd255;
         end else begin
            result[8*k +: 8] = sum[7:0];
         end
      end
   end

endmodule

FILE: rtl/rgb_sharpen_3x3_stream.sv
// Top level of the RGB 3x3 sharpen stream: counters, line stores, window cells.
// Depends on rss_pkg, rss_ram, rss_cell and rss_filter.
//
// Usage:
//   req_* carries one pixel per beat in raster order; req_tuser is the command
//   (0 = pixel, 1 = drain tick). After the last pixel of a frame send
//   image_width+1 drain beats to flush the last row plus one pixel.
//   rsp_* returns one sharpened pixel per result; rsp_tlast marks the last
//   pixel of the frame, after which the next beat starts a new frame.
//   csr_* writes image_width (index 0) or image_height (index 1) while the
//   block is idle; a write restarts the frame. csr_ready is always high.
//   Throughput: one beat per cycle unless rsp_* stalls. A result reaches rsp_*
//   from the beat that completes it through the registered line-store read,
//   then the window update and kernel into the output register.
//   A result lags its center pixel by image_width+1 beats (the line stores).
//   Reset clears the counters, window and pipeline; line stores are not
//   cleared. When rsp_tready is low the result holds in the output register;
//   one more beat is taken into the read stage, then req_tready drops.
module rgb_sharpen_3x3_stream (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // in_red [7:0], in_green [15:8], in_blue [23:16]
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_red [7:0], out_green [15:8], out_blue [23:16]
   output logic        rsp_tlast,   // frame_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [rss_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int CW = rss_pkg::COL_W;
   localparam int WW = rss_pkg::WIDTH_W;
   localparam int HW = rss_pkg::HEIGHT_W;

   logic [WW-1:0] eff_w_ff, eff_w_in;
   logic [HW-1:0] eff_h_ff, eff_h_in;
   logic [CW-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [HW-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;

   rss_pkg::stage_type s1_ff, s1_in;
   logic               s1_valid_ff;
   logic               rsp_valid_ff;
   rss_pkg::pixel_type rsp_data_ff;
   logic               rsp_last_ff;

   logic               accept, s1_fire, csr_write;
   logic [CW-1:0]      c;
   logic [WW-1:0]      c_next;
   rss_pkg::pixel_type older_q, newer_q, pix_in, result;
   rss_pkg::pixel_type up_px, down_px, left_px, right_px;
   rss_pkg::column_type new_col;
   rss_pkg::column_type win [3];

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid;
   assign s1_fire   = s1_valid_ff && (!s1_ff.emit || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign accept    = req_tvalid && req_tready;

   // Register writes: clamp to the supported range.
   always_comb begin
      logic [WW-1:0] wv;
      logic [HW-1:0] hv;
      wv = csr_data[WW-1:0];
      hv = csr_data[HW-1:0];
      eff_w_in = eff_w_ff;
      eff_h_in = eff_h_ff;
      if (csr_write && csr_index == rss_pkg::REG_WIDTH) begin
         if (wv < rss_pkg::MIN_WIDTH) begin
            eff_w_in = rss_pkg::MIN_WIDTH;
         end else if (wv > rss_pkg::LIMIT_WIDTH) begin
            eff_w_in = rss_pkg::LIMIT_WIDTH;
         end else begin
            eff_w_in = wv;
         end
      end
      if (csr_write && csr_index == rss_pkg::REG_HEIGHT) begin
         eff_h_in = (hv < rss_pkg::MIN_HEIGHT) ? rss_pkg::MIN_HEIGHT : hv;
      end
   end

   // Position counters and per-beat control, all settled at acceptance.
   always_comb begin
      logic emit, fend;
      c      = ({1'b0, in_col_ff} < eff_w_ff) ? in_col_ff : '0;
      c_next = {1'b0, c} + WW'(1);
      emit   = (in_row_ff >= HW'(2)) || (in_row_ff == HW'(1) && c != '0);
      fend   = emit && (out_row_ff == eff_h_ff - HW'(1))
                    && ({1'b0, out_col_ff} == eff_w_ff - WW'(1));
      pix_in = (req_tuser == rss_pkg::CMD_PIXEL && in_row_ff < eff_h_ff) ?
               {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]} : '0;

      s1_in.emit   = emit;
      s1_in.first  = (c == '0);
      s1_in.second = (c == CW'(1));
      s1_in.top    = (out_row_ff == '0);
      s1_in.bot    = (out_row_ff >= eff_h_ff - HW'(1));
      s1_in.fend   = fend;
      s1_in.col    = c;
      s1_in.pix    = pix_in;

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (csr_write) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (accept) begin
         if (emit) begin
            if ({1'b0, out_col_ff} + WW'(1) >= eff_w_ff) begin
               out_col_in = '0;
               out_row_in = out_row_ff + HW'(1);
            end else begin
               out_col_in = out_col_ff + CW'(1);
            end
         end
         if (c_next >= eff_w_ff) begin
            in_col_in = '0;
            if (in_row_ff < eff_h_ff) begin
               in_row_in = in_row_ff + HW'(1);
            end
         end else begin
            in_col_in = c_next[CW-1:0];
         end
         if (fend) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff    <= rss_pkg::RESET_WIDTH;
         eff_h_ff    <= rss_pkg::RESET_HEIGHT;
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         eff_w_ff    <= eff_w_in;
         eff_h_ff    <= eff_h_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // Line stores: read on accept, write back as the beat leaves the read stage.
   rss_ram #(.WIDTH(24), .DEPTH(rss_pkg::MAX_WIDTH)) u_older (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_ff.col),
      .wr_data (newer_q),
      .rd_en   (accept),
      .rd_addr (c),
      .rd_data (older_q)
   );

   rss_ram #(.WIDTH(24), .DEPTH(rss_pkg::MAX_WIDTH)) u_newer (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_ff.col),
      .wr_data (s1_ff.pix),
      .rd_en   (accept),
      .rd_addr (c),
      .rd_data (newer_q)
   );

   // Window: a chain of three column cells, newest column enters cell 2.
   assign new_col[0] = older_q;
   assign new_col[1] = newer_q;
   assign new_col[2] = s1_ff.pix;

   rss_cell u_cell2 (.clock(clock), .reset(reset), .shift(s1_fire),
                     .col_in(new_col), .col_out(win[2]));
   rss_cell u_cell1 (.clock(clock), .reset(reset), .shift(s1_fire),
                     .col_in(win[2]), .col_out(win[1]));
   rss_cell u_cell0 (.clock(clock), .reset(reset), .shift(s1_fire),
                     .col_in(win[1]), .col_out(win[0]));

   // Center column is the one in cell 2 before the shift; rows and columns clamp at edges.
   assign up_px    = s1_ff.top ? win[2][1] : win[2][0];
   assign down_px  = s1_ff.bot ? win[2][1] : win[2][2];
   assign left_px  = s1_ff.second ? win[2][1] : win[1][1];
   assign right_px = s1_ff.first ? win[2][1] : newer_q;

   rss_filter u_filter (
      .center (win[2][1]),
      .up     (up_px),
      .down   (down_px),
      .left   (left_px),
      .right  (right_px),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire && s1_ff.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_ff.emit) begin
         rsp_data_ff <= result;
         rsp_last_ff <= s1_ff.fend;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff[7:0], rsp_data_ff[15:8], rsp_data_ff[23:16]};
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: sim/tb_rgb_sharpen_3x3_stream.sv
// Self-checking bench for rgb_sharpen_3x3_stream: drives raster frames with random idle
// and backpressure and compares every result beat with an in-bench sharpen predictor.
// Depends on rss_pkg and the rgb_sharpen_3x3_stream RTL.
module tb_rgb_sharpen_3x3_stream;

   localparam int CYCLE_LIMIT   = 400_000;
   localparam int RANDOM_BEATS  = 1100;
   localparam int DEFAULT_EXTRA = 40;
   localparam int WIDE_BEATS    = 24;
   localparam int SETTLE_CYCLES = 8;
   localparam int REPORT_LIMIT  = 10;
   localparam int WIDTH_ALL     = (1 << rss_pkg::WIDTH_W) - 1;
   localparam int HEIGHT_ALL    = (1 << rss_pkg::HEIGHT_W) - 1;

   typedef enum int {STYLE_NOISE, STYLE_SMOOTH, STYLE_BINARY} pixel_style_type;
   typedef struct packed {
      rss_pkg::pixel_type data;
      logic               last;
   } sharp_pixel_type;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [23:0]                    req_tdata;
   logic                           req_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [23:0]                    rsp_tdata;
   logic                           rsp_tlast;
   logic                           csr_valid;
   logic                           csr_ready;
   logic                           csr_index;
   logic [rss_pkg::CSR_DATA_W-1:0] csr_data;

   // sharpen predictor state
   rss_pkg::pixel_type           prev2_row [0:rss_pkg::MAX_WIDTH-1];
   rss_pkg::pixel_type           prev1_row [0:rss_pkg::MAX_WIDTH-1];
   rss_pkg::pixel_type           nbhd [0:8];
   int                           feed_col, feed_row, emit_col, emit_row;
   logic [rss_pkg::WIDTH_W-1:0]  cfg_width;
   logic [rss_pkg::HEIGHT_W-1:0] cfg_height;

   sharp_pixel_type expected_pixels [$];
   sharp_pixel_type checker_want;
   int              mismatches;
   int              beats_sent;
   bit              quiet_idle;

   rgb_sharpen_3x3_stream dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic int eff_width();
      int w;
      w = int'(cfg_width);
      if (w < 2) w = 2;
      if (w > rss_pkg::MAX_WIDTH) w = rss_pkg::MAX_WIDTH;
      return w;
   endfunction

   function automatic int eff_height();
      int h;
      h = int'(cfg_height);
      if (h < 2) h = 2;
      return h;
   endfunction

   function automatic int chan(input rss_pkg::pixel_type p, input int k);
      return int'(p[8*k +: 8]);
   endfunction

   function automatic rss_pkg::pixel_type sharpen_window(input int lc, input int cc,
                                                         input int rc, input int h);
      int                 top, bot, k, s;
      rss_pkg::pixel_type res;
      top = (emit_row == 0) ? 1 : 0;
      bot = (emit_row >= h - 1) ? 1 : 2;
      for (k = 0; k < 3; k++) begin
         s = 5 * chan(nbhd[3 + cc], k) - chan(nbhd[3*top + cc], k)
             - chan(nbhd[3*bot + cc], k) - chan(nbhd[3 + lc], k) - chan(nbhd[3 + rc], k);
         if (s < 0) s = 0;
         if (s > 255) s = 255;
         res[8*k +: 8] = 8'(s);
      end
      return res;
   endfunction

   task automatic predict_sharpen_beat(input logic cmd, input rss_pkg::pixel_type pix_in);
      int                 w, h, c, r;
      rss_pkg::pixel_type pix, col0, col1;
      logic               emit;
      sharp_pixel_type    res;
      w = eff_width();
      h = eff_height();
      c = (feed_col < w) ? feed_col : 0;
      emit = (feed_row >= 2) || (feed_row == 1 && c >= 1);
      res = '0;
      pix = (cmd == rss_pkg::CMD_PIXEL && feed_row < h) ? pix_in : '0;
      // right edge of the previous row completes before the window shifts
      if (emit && c == 0) res.data = sharpen_window(1, 2, 2, h);
      col0 = prev2_row[c];
      col1 = prev1_row[c];
      prev2_row[c] = col1;
      prev1_row[c] = pix;
      for (r = 0; r < 3; r++) begin
         nbhd[3*r]     = nbhd[3*r + 1];
         nbhd[3*r + 1] = nbhd[3*r + 2];
         nbhd[3*r + 2] = (r == 0) ? col0 : (r == 1) ? col1 : pix;
      end
      if (emit && c != 0) res.data = sharpen_window((c == 1) ? 1 : 0, 1, 2, h);
      if (emit) begin
         res.last = (emit_row == h - 1) && (emit_col == w - 1);
         expected_pixels.push_back(res);
         emit_col++;
         if (emit_col >= w) begin
            emit_col = 0;
            emit_row++;
         end
      end
      feed_col = c + 1;
      if (feed_col >= w) begin
         feed_col = 0;
         if (feed_row < h) feed_row++;
      end
      if (emit && res.last) begin
         feed_col = 0;
         feed_row = 0;
         emit_col = 0;
         emit_row = 0;
      end
   endtask

   function automatic void load_size_reg(input logic idx, input int unsigned value);
      if (idx == rss_pkg::REG_WIDTH) cfg_width = value[rss_pkg::WIDTH_W-1:0];
      else cfg_height = value[rss_pkg::HEIGHT_W-1:0];
      feed_col = 0;
      feed_row = 0;
      emit_col = 0;
      emit_row = 0;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 20);
   endfunction

   function automatic rss_pkg::pixel_type make_pixel(input pixel_style_type style,
                                                     input logic [7:0] level);
      rss_pkg::pixel_type p;
      int                 k;
      for (k = 0; k < 3; k++) begin
         case (style)
            STYLE_NOISE:  p[8*k +: 8] = 8'($urandom);
            STYLE_SMOOTH: p[8*k +: 8] = level + 8'($urandom_range(0, 31));
            default:      p[8*k +: 8] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         endcase
      end
      return p;
   endfunction

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%0t mismatch: %s", $time, msg);
   endtask

   task automatic send_beat(input logic cmd, input rss_pkg::pixel_type pix);
      int gap;
      gap = quiet_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
      predict_sharpen_beat(cmd, pix);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_frame_size(input int unsigned wv, input int unsigned hv);
      csr_valid <= 1'b1;
      csr_index <= rss_pkg::REG_WIDTH;
      csr_data  <= rss_pkg::CSR_DATA_W'(wv);
      do @(posedge clock); while (!csr_ready);
      load_size_reg(rss_pkg::REG_WIDTH, wv);
      @(negedge clock);
      csr_index <= rss_pkg::REG_HEIGHT;
      csr_data  <= rss_pkg::CSR_DATA_W'(hv);
      do @(posedge clock); while (!csr_ready);
      load_size_reg(rss_pkg::REG_HEIGHT, hv);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // full frame plus drain unless cut short at random
   task automatic send_frame(input bit allow_break, output bit broken);
      int              w, h, n, k;
      pixel_style_type style;
      logic [7:0]      level;
      w = eff_width();
      h = eff_height();
      broken = allow_break && ($urandom_range(0, 9) == 0);
      n = broken ? $urandom_range(1, w * h) : w * h;
      style = pixel_style_type'($urandom_range(0, 2));
      level = 8'($urandom_range(0, 224));
      for (k = 0; k < n; k++) begin
         if ($urandom_range(0, 31) == 0) send_beat(rss_pkg::CMD_DRAIN, make_pixel(style, level));
         else send_beat(rss_pkg::CMD_PIXEL, make_pixel(style, level));
      end
      if (!broken) begin
         for (k = 0; k <= w; k++) begin
            if ($urandom_range(0, 3) == 0)
               send_beat(rss_pkg::CMD_PIXEL, make_pixel(STYLE_NOISE, 0));
            else
               send_beat(rss_pkg::CMD_DRAIN, make_pixel(STYLE_NOISE, 0));
         end
      end
   endtask

   task automatic test_default_size();
      int              k;
      pixel_style_type style;
      style = STYLE_SMOOTH;
      for (k = 0; k < int'(rss_pkg::RESET_WIDTH) + DEFAULT_EXTRA; k++) begin
         if (k % int'(rss_pkg::RESET_WIDTH) == 0) style = pixel_style_type'($urandom_range(0, 2));
         send_beat(rss_pkg::CMD_PIXEL, make_pixel(style, 8'($urandom_range(0, 224))));
      end
      wait_idle();
   endtask

   task automatic test_smallest_frames();
      int k;
      set_frame_size(0, 1);
      send_beat(rss_pkg::CMD_PIXEL, 24'hFFFFFF);
      send_beat(rss_pkg::CMD_PIXEL, 24'h000000);
      send_beat(rss_pkg::CMD_PIXEL, 24'h000000);
      send_beat(rss_pkg::CMD_PIXEL, 24'h80FF7F);
      for (k = 0; k < 3; k++) send_beat(rss_pkg::CMD_DRAIN, 24'h000000);
      wait_idle();
      set_frame_size(1, 0);
      send_beat(rss_pkg::CMD_PIXEL, 24'h00FF80);
      send_beat(rss_pkg::CMD_PIXEL, 24'h7F0001);
      send_beat(rss_pkg::CMD_PIXEL, 24'hFE01FF);
      send_beat(rss_pkg::CMD_PIXEL, 24'h405060);
      for (k = 0; k < 3; k++) send_beat(rss_pkg::CMD_DRAIN, 24'hFFFFFF);
      wait_idle();
   endtask

   task automatic test_special_beats();
      bit broken;
      set_frame_size(3, 3);
      send_beat(rss_pkg::CMD_PIXEL, 24'h102030);
      send_beat(rss_pkg::CMD_PIXEL, 24'hF0E0D0);
      send_beat(rss_pkg::CMD_PIXEL, 24'h0F0F0F);
      send_beat(rss_pkg::CMD_DRAIN, 24'hFFFFFF);
      send_beat(rss_pkg::CMD_PIXEL, 24'h404040);
      send_beat(rss_pkg::CMD_PIXEL, 24'h7F807F);
      send_beat(rss_pkg::CMD_PIXEL, 24'h000000);
      send_beat(rss_pkg::CMD_PIXEL, 24'hFF00FF);
      send_beat(rss_pkg::CMD_PIXEL, 24'h01FE01);
      send_beat(rss_pkg::CMD_PIXEL, 24'h123456);
      send_beat(rss_pkg::CMD_DRAIN, 24'hABCDEF);
      send_beat(rss_pkg::CMD_PIXEL, 24'hFFFFFF);
      send_beat(rss_pkg::CMD_DRAIN, 24'h000000);
      // next frame follows frame end with no register write
      send_frame(1'b0, broken);
      wait_idle();
   endtask

   task automatic test_widest_frames();
      int k;
      set_frame_size(rss_pkg::MAX_WIDTH, 2);
      for (k = 0; k < WIDE_BEATS; k++)
         send_beat(rss_pkg::CMD_PIXEL, make_pixel(STYLE_NOISE, 0));
      wait_idle();
      set_frame_size(WIDTH_ALL, 2);
      for (k = 0; k < WIDE_BEATS; k++)
         send_beat(rss_pkg::CMD_PIXEL, make_pixel(STYLE_NOISE, 0));
      wait_idle();
   endtask

   task automatic test_tallest_frame();
      int k;
      set_frame_size(2, HEIGHT_ALL);
      for (k = 0; k < 40; k++) begin
         if (k % 13 == 7) send_beat(rss_pkg::CMD_DRAIN, make_pixel(STYLE_NOISE, 0));
         else send_beat(rss_pkg::CMD_PIXEL, make_pixel(STYLE_NOISE, 0));
      end
      wait_idle();
   endtask

   task automatic test_random_frames();
      int start, frames, f, w, h;
      bit broken;
      start = beats_sent;
      while (beats_sent - start < RANDOM_BEATS) begin
         case ($urandom_range(0, 19))
            0:       w = $urandom_range(0, 1);
            1:       w = $urandom_range(13, 32);
            default: w = $urandom_range(2, 12);
         endcase
         case ($urandom_range(0, 19))
            0:       h = $urandom_range(0, 1);
            1:       h = $urandom_range(9, 12);
            default: h = $urandom_range(2, 8);
         endcase
         quiet_idle = ($urandom_range(0, 3) == 0);
         wait_idle();
         set_frame_size(w, h);
         frames = $urandom_range(1, 3);
         for (f = 0; f < frames; f++) begin
            send_frame(1'b1, broken);
            if (broken || beats_sent - start >= RANDOM_BEATS) break;
         end
      end
      quiet_idle = 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            note_mismatch($sformatf("unexpected beat data=%h last=%b", rsp_tdata, rsp_tlast));
         end else begin
            checker_want = expected_pixels.pop_front();
            if (rsp_tdata[7:0] !== checker_want.data[7:0] ||
                rsp_tdata[15:8] !== checker_want.data[15:8] ||
                rsp_tdata[23:16] !== checker_want.data[23:16] ||
                rsp_tlast !== checker_want.last)
               note_mismatch($sformatf(
                  "red %h/%h green %h/%h blue %h/%h last %b/%b (expected/actual)",
                  checker_want.data[7:0], rsp_tdata[7:0],
                  checker_want.data[15:8], rsp_tdata[15:8],
                  checker_want.data[23:16], rsp_tdata[23:16],
                  checker_want.last, rsp_tlast));
         end
      end
   end

   initial begin
      int stall;
      stall = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            stall = quiet_idle ? 0 : pick_gap();
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb_rgb_sharpen_3x3_stream: done, errors");
      $finish;
   end

   initial begin
      int k;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = rss_pkg::CMD_PIXEL;
      csr_valid  = 1'b0;
      csr_index  = rss_pkg::REG_WIDTH;
      csr_data   = '0;
      cfg_width  = rss_pkg::RESET_WIDTH;
      cfg_height = rss_pkg::RESET_HEIGHT;
      feed_col   = 0;
      feed_row   = 0;
      emit_col   = 0;
      emit_row   = 0;
      for (k = 0; k < 9; k++) nbhd[k] = '0;
      mismatches = 0;
      beats_sent = 0;
      quiet_idle = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_size();
      test_smallest_frames();
      test_special_beats();
      test_widest_frames();
      test_tallest_frame();
      test_random_frames();

      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_pixels.size() == 0)
         $display("tb_rgb_sharpen_3x3_stream: done, clean");
      else
         $display("tb_rgb_sharpen_3x3_stream: done, errors");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/rss_pkg.sv
rtl/rss_ram.sv
rtl/rss_cell.sv
rtl/rss_filter.sv
rtl/rgb_sharpen_3x3_stream.sv
sim/tb_rgb_sharpen_3x3_stream.sv
